// ----- rtl/voxel_region_site_marker_macros.svh -----
// Assertion macros for the voxel region site marker.
`ifndef VOXEL_REGION_SITE_MARKER_MACROS_SVH
`define VOXEL_REGION_SITE_MARKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VRSM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/vrsm_pkg.sv -----
// Package: item types, mode and register codes, widths for the site marker.
`timescale 1ns / 1ps

package vrsm_pkg;

	localparam int COORD_W  = 8;
	localparam int MASK_W   = 16;
	localparam int GEOM_W   = 14;
	localparam int RADIUS_W = 13;
	localparam int MODE_W   = 4;
	localparam int COUNT_W  = 25;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;
	localparam int SITE_IDX = 14;

	localparam logic [MASK_W-1:0]  SITE_BIT  = 16'h4000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 25'd16777216;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALL    = 4'd0,
		MODE_CLEAR  = 4'd1,
		MODE_SLAB   = 4'd2,
		MODE_SPHERE = 4'd3,
		MODE_CYL_X  = 4'd4,
		MODE_CYL_Y  = 4'd5,
		MODE_CYL_Z  = 4'd6,
		MODE_HOLE_X = 4'd7,
		MODE_HOLE_Y = 4'd8,
		MODE_HOLE_Z = 4'd9
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_POINT_A = 3'd1,
		REG_POINT_B = 3'd2,
		REG_POINT_C = 3'd3,
		REG_UPPER_X = 3'd4,
		REG_UPPER_Y = 3'd5,
		REG_UPPER_Z = 3'd6,
		REG_RADIUS  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [COORD_W-1:0] coord_z;
		logic [MASK_W-1:0]  mask_in;
		logic               last_node;
	} node_t;

	typedef struct packed {
		logic [MASK_W-1:0]  mask_out;
		logic               site_changed;
		logic [COUNT_W-1:0] site_count;
	} site_t;

endpackage

// ----- rtl/vrsm_stream_if.sv -----
// Valid/ready stream interface carrying one item per handshake.
`timescale 1ns / 1ps

interface vrsm_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/voxel_region_site_marker.sv -----
// Voxel region site marker: marks adsorption sites on lattice nodes in a region, or clears them.
// A node passes register stages s1, s2 and s3 in order; s3 drives sites (three register stages).
// Throughput: one node per cycle unless the output stalls; a stage refills as the next moves on.
// The radius-squared register is updated in the cycle after radius_q takes a write.
// Reset clears configuration registers, the pass count and all stage valid flags.
`timescale 1ns / 1ps

module voxel_region_site_marker #(
	parameter int COORD_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vrsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vrsm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	vrsm_stream_if.sink                       nodes,
	vrsm_stream_if.source                     sites
);

`include "voxel_region_site_marker_macros.svh"

	localparam int CU   = (COORD_BITS < vrsm_pkg::COORD_W) ? COORD_BITS : vrsm_pkg::COORD_W;
	localparam int SW   = CU + 4;
	localparam int DW   = ((SW + 1 > vrsm_pkg::GEOM_W) ? SW + 1 : vrsm_pkg::GEOM_W) + 1;
	localparam int QW   = 2 * DW;
	localparam int SUMW = QW + 2;
	localparam int RQW  = 2 * vrsm_pkg::RADIUS_W;
	localparam int CMPW = (SUMW > RQW) ? SUMW : RQW;

	// configuration
	logic [vrsm_pkg::MODE_W-1:0]          region_mode_q;
	logic signed [vrsm_pkg::GEOM_W-1:0]   point_a_q, point_b_q, point_c_q;
	logic signed [vrsm_pkg::GEOM_W-1:0]   upper_x_q, upper_y_q, upper_z_q;
	logic [vrsm_pkg::RADIUS_W-1:0]        radius_q;
	logic [RQW-1:0]                       rsq_q;
	logic [vrsm_pkg::COUNT_W-1:0]         pass_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_mode_q <= '0;
			point_a_q     <= '0;
			point_b_q     <= '0;
			point_c_q     <= '0;
			upper_x_q     <= '0;
			upper_y_q     <= '0;
			upper_z_q     <= '0;
			radius_q      <= '0;
			rsq_q         <= '0;
		end else begin
			rsq_q <= radius_q * radius_q;
			if (cfg_we) begin
				unique case (vrsm_pkg::reg_idx_t'(cfg_index))
					vrsm_pkg::REG_MODE:    region_mode_q <= cfg_wdata[vrsm_pkg::MODE_W-1:0];
					vrsm_pkg::REG_POINT_A: point_a_q <= cfg_wdata[vrsm_pkg::GEOM_W-1:0];
					vrsm_pkg::REG_POINT_B: point_b_q <= cfg_wdata[vrsm_pkg::GEOM_W-1:0];
					vrsm_pkg::REG_POINT_C: point_c_q <= cfg_wdata[vrsm_pkg::GEOM_W-1:0];
					vrsm_pkg::REG_UPPER_X: upper_x_q <= cfg_wdata[vrsm_pkg::GEOM_W-1:0];
					vrsm_pkg::REG_UPPER_Y: upper_y_q <= cfg_wdata[vrsm_pkg::GEOM_W-1:0];
					vrsm_pkg::REG_UPPER_Z: upper_z_q <= cfg_wdata[vrsm_pkg::GEOM_W-1:0];
					vrsm_pkg::REG_RADIUS:  radius_q <= cfg_wdata[vrsm_pkg::RADIUS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// stage enables: a stage loads when empty or when its contents move on
	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	assign en_s3       = !v_s3 || sites.ready;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign nodes.ready = en_s1;

	// input side: scale coordinates to sixteenths, form differences and slab test
	logic signed [DW-1:0] xe, ye, ze;
	logic signed [DW-1:0] pa, pb, pc, ux, uy, uz;
	logic signed [DW-1:0] d0, d1, d2;
	logic                 slab_in;

	assign xe = $signed({{(DW-SW){1'b0}}, nodes.data.coord_x[CU-1:0], 4'b0000});
	assign ye = $signed({{(DW-SW){1'b0}}, nodes.data.coord_y[CU-1:0], 4'b0000});
	assign ze = $signed({{(DW-SW){1'b0}}, nodes.data.coord_z[CU-1:0], 4'b0000});

	assign pa = {{(DW-vrsm_pkg::GEOM_W){point_a_q[vrsm_pkg::GEOM_W-1]}}, point_a_q};
	assign pb = {{(DW-vrsm_pkg::GEOM_W){point_b_q[vrsm_pkg::GEOM_W-1]}}, point_b_q};
	assign pc = {{(DW-vrsm_pkg::GEOM_W){point_c_q[vrsm_pkg::GEOM_W-1]}}, point_c_q};
	assign ux = {{(DW-vrsm_pkg::GEOM_W){upper_x_q[vrsm_pkg::GEOM_W-1]}}, upper_x_q};
	assign uy = {{(DW-vrsm_pkg::GEOM_W){upper_y_q[vrsm_pkg::GEOM_W-1]}}, upper_y_q};
	assign uz = {{(DW-vrsm_pkg::GEOM_W){upper_z_q[vrsm_pkg::GEOM_W-1]}}, upper_z_q};

	assign slab_in = (xe > pa) && (xe < ux) && (ye > pb) && (ye < uy) &&
			(ze > pc) && (ze < uz);

	always_comb begin
		d0 = xe - pa;
		d1 = ye - pb;
		d2 = ze - pc;
		unique case (region_mode_q)
			vrsm_pkg::MODE_CYL_X, vrsm_pkg::MODE_HOLE_X: begin
				d0 = ye - pa;
				d1 = ze - pb;
				d2 = '0;
			end
			vrsm_pkg::MODE_CYL_Y, vrsm_pkg::MODE_HOLE_Y: begin
				d1 = ze - pb;
				d2 = '0;
			end
			vrsm_pkg::MODE_CYL_Z, vrsm_pkg::MODE_HOLE_Z: begin
				d2 = '0;
			end
			default: ;
		endcase
	end

	// stage 1
	logic signed [DW-1:0]         d0_s1, d1_s1, d2_s1;
	logic                         slab_s1;
	logic [vrsm_pkg::MASK_W-1:0]  mask_s1;
	logic                         last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= nodes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && nodes.valid) begin
			d0_s1   <= d0;
			d1_s1   <= d1;
			d2_s1   <= d2;
			slab_s1 <= slab_in;
			mask_s1 <= nodes.data.mask_in;
			last_s1 <= nodes.data.last_node;
		end
	end

	// stage 2: squares
	logic signed [QW-1:0]         p0, p1, p2;
	logic [QW-1:0]                sq0_s2, sq1_s2, sq2_s2;
	logic                         slab_s2;
	logic [vrsm_pkg::MASK_W-1:0]  mask_s2;
	logic                         last_s2;

	assign p0 = d0_s1 * d0_s1;
	assign p1 = d1_s1 * d1_s1;
	assign p2 = d2_s1 * d2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			sq0_s2  <= unsigned'(p0);
			sq1_s2  <= unsigned'(p1);
			sq2_s2  <= unsigned'(p2);
			slab_s2 <= slab_s1;
			mask_s2 <= mask_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: region decision, mask update and pass count
	logic [SUMW-1:0]               dist_sum;
	logic                          in_radius;
	logic                          in_region;
	logic                          changed;
	logic [vrsm_pkg::MASK_W-1:0]   mask_new;
	logic [vrsm_pkg::COUNT_W-1:0]  count_next;

	assign dist_sum  = SUMW'(sq0_s2) + SUMW'(sq1_s2) + SUMW'(sq2_s2);
	assign in_radius = CMPW'(dist_sum) < CMPW'(rsq_q);

	always_comb begin
		unique case (region_mode_q)
			vrsm_pkg::MODE_ALL:    in_region = 1'b1;
			vrsm_pkg::MODE_SLAB:   in_region = slab_s2;
			vrsm_pkg::MODE_SPHERE,
			vrsm_pkg::MODE_CYL_X,
			vrsm_pkg::MODE_CYL_Y,
			vrsm_pkg::MODE_CYL_Z:  in_region = in_radius;
			vrsm_pkg::MODE_HOLE_X,
			vrsm_pkg::MODE_HOLE_Y,
			vrsm_pkg::MODE_HOLE_Z: in_region = !in_radius;
			default:               in_region = 1'b0;
		endcase
	end

	always_comb begin
		if (region_mode_q == vrsm_pkg::MODE_CLEAR) begin
			changed  = mask_s2[vrsm_pkg::SITE_IDX];
			mask_new = mask_s2 & ~vrsm_pkg::SITE_BIT;
		end else begin
			changed  = in_region && (mask_s2 != '0);
			mask_new = changed ? (mask_s2 | vrsm_pkg::SITE_BIT) : mask_s2;
		end
	end

	// count saturates at COUNT_MAX
	assign count_next = (changed && (pass_count_q < vrsm_pkg::COUNT_MAX)) ?
			pass_count_q + 1'b1 : pass_count_q;

	logic [vrsm_pkg::MASK_W-1:0]   mask_out_s3;
	logic                          changed_s3;
	logic [vrsm_pkg::COUNT_W-1:0]  count_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3         <= 1'b0;
			pass_count_q <= '0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
			if (v_s2) begin
				pass_count_q <= last_s2 ? '0 : count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			mask_out_s3 <= mask_new;
			changed_s3  <= changed;
			count_s3    <= count_next;
		end
	end

	assign sites.valid             = v_s3;
	assign sites.data.mask_out     = mask_out_s3;
	assign sites.data.site_changed = changed_s3;
	assign sites.data.site_count   = count_s3;

	`VRSM_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, pass_count_q <= vrsm_pkg::COUNT_MAX, "pass count beyond saturation")
	`VRSM_ASSERT_IMPL(a_changed_counted, clk, arst_n, v_s3 && changed_s3, count_s3 != '0, "changed site reported with zero count")
	`VRSM_ASSERT_IMPL(a_clear_bit, clk, arst_n, v_s3 && (region_mode_q == vrsm_pkg::MODE_CLEAR), !mask_out_s3[vrsm_pkg::SITE_IDX], "site bit left set in clear mode")
	`VRSM_ASSERT_IMPL(a_mark_bit, clk, arst_n, v_s3 && changed_s3 && (region_mode_q != vrsm_pkg::MODE_CLEAR), mask_out_s3[vrsm_pkg::SITE_IDX], "marked site without site bit")
	`VRSM_ASSERT_NEXT(a_pass_clear, clk, arst_n, en_s3 && v_s2 && last_s2, pass_count_q == '0, "count not cleared after last node")

endmodule
